// File: rtl/wsm_pkg.sv
package wsm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_CHAR = 8'h2A;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_START   = 2'd2,
    CMD_SUBJECT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_APPEND,
    CELL_START,
    CELL_SUBJECT,
    CELL_PROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] ch;
    logic       star_wild;
  } cell_ctl_t;

  typedef struct packed {
    logic changed;
    logic hit;
  } row_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_PROP
  } state_t;

endpackage

// File: rtl/wildcard_star_matcher_core.sv
// Glob matcher with wildcard stars. Load a pattern one char per item (command 1,
// tuser[2] makes a '*' a wildcard), then send a start item (command 2) and the
// subject chars (command 3); each start and subject item returns one result
// item: matched (prefix so far matches the whole pattern) and the sticky
// pattern overflow flag. Clear and append items are taken in the idle state.
// A start or subject item moves the block to a propagate state, left once the
// match front has stopped travelling along a run of wildcard stars (the row of
// cells moves it one position per cycle) and the output is free for the
// result; no new item is taken in that state.
module wildcard_star_matcher_core
  import wsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_code
  input  logic [2:0] s_tuser,   // command[1:0], star_is_wild
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // matched, pattern_overflow, zero padding
);

  cell_ctl_t              ctl;
  row_stat_t              stat;
  logic [LEN_W-1:0]       len;
  logic                   origin;
  logic [MAX_PATTERN-1:0] row_bits;
  logic [MAX_PATTERN-1:0] row_active;
  logic [MAX_PATTERN-1:0] row_change;
  logic [MAX_PATTERN-1:0] row_hit;

  wsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .stat     (stat),
    .ctl      (ctl),
    .len      (len),
    .origin   (origin)
  );

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic left;
    logic next_active;
    logic sel;

    if (j == 0) begin : g_first
      assign left = origin;
    end else begin : g_mid
      assign left = row_bits[j-1];
    end

    if (j == MAX_PATTERN - 1) begin : g_last
      assign next_active = 1'b0;
    end else begin : g_inner
      assign next_active = row_active[j+1];
    end

    assign sel = (len == LEN_W'(j));

    wsm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .sel         (sel),
      .left        (left),
      .next_active (next_active),
      .match_bit   (row_bits[j]),
      .active      (row_active[j]),
      .change      (row_change[j]),
      .hit         (row_hit[j])
    );
  end

  assign stat.changed = |row_change;
  assign stat.hit     = |row_hit;

endmodule

// File: rtl/wsm_cell.sv
module wsm_cell
  import wsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  logic      left,
  input  logic      next_active,
  output logic      match_bit,
  output logic      active,
  output logic      change,
  output logic      hit
);

  logic [7:0] pat_char;
  logic       wild;
  logic       subj_next;

  // wild: take own old bit (star absorbs the char); literal: diagonal on equal char
  assign subj_next = active & (wild ? match_bit : ((pat_char == ctl.ch) & left));

  // front still moving along a run of stars
  assign change = wild & left & ~match_bit;
  assign hit    = match_bit & ~next_active;

  always_ff @(posedge clk) begin
    if (ctl.op == CELL_APPEND && sel) begin
      pat_char <= ctl.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wild      <= 1'b0;
      active    <= 1'b0;
      match_bit <= 1'b0;
    end else begin
      unique case (ctl.op)
        CELL_HOLD: begin
        end
        CELL_CLEAR: begin
          wild      <= 1'b0;
          active    <= 1'b0;
          match_bit <= 1'b0;
        end
        CELL_APPEND: begin
          match_bit <= 1'b0;
          if (sel) begin
            active <= 1'b1;
            wild   <= (ctl.ch == STAR_CHAR) && ctl.star_wild;
          end
        end
        CELL_START: begin
          match_bit <= 1'b0;
        end
        CELL_SUBJECT: begin
          match_bit <= subj_next;
        end
        CELL_PROP: begin
          match_bit <= match_bit | (wild & left);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/wsm_ctrl.sv
module wsm_ctrl
  import wsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic [2:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  input  row_stat_t        stat,
  output cell_ctl_t        ctl,
  output logic [LEN_W-1:0] len,
  output logic             origin
);

  state_t     state;
  state_t     state_next;
  cmd_t       cmd;
  logic       accept;
  logic       out_free;
  logic       done;
  logic       full;
  logic       overflow;
  logic       res_matched;
  logic       res_overflow;

  assign cmd      = cmd_t'(s_tuser[1:0]);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign done     = (state == ST_PROP) && !stat.changed && out_free;
  assign full     = (len == LEN_W'(MAX_PATTERN));
  assign m_tdata  = {6'b0, res_overflow, res_matched};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_START || cmd == CMD_SUBJECT)) begin
          state_next = ST_PROP;
        end
      end
      ST_PROP: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.ch        = s_tdata;
    ctl.star_wild = s_tuser[2];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR:   ctl.op = CELL_CLEAR;
            CMD_APPEND:  ctl.op = CELL_APPEND;
            CMD_START:   ctl.op = CELL_START;
            CMD_SUBJECT: ctl.op = CELL_SUBJECT;
            default:     ctl.op = CELL_HOLD;
          endcase
        end
      end
      ST_PROP: ctl.op = CELL_PROP;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      len      <= '0;
      overflow <= 1'b0;
      origin   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (cmd)
          CMD_CLEAR: begin
            len      <= '0;
            overflow <= 1'b0;
            origin   <= 1'b0;
          end
          CMD_APPEND: begin
            origin <= 1'b0;
            if (full) begin
              overflow <= 1'b1;
            end else begin
              len <= len + LEN_W'(1);
            end
          end
          CMD_START:   origin <= 1'b1;
          CMD_SUBJECT: origin <= 1'b0;
          default: begin
          end
        endcase
      end
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // empty pattern: only the origin column counts
  always_ff @(posedge clk) begin
    if (done) begin
      res_matched  <= (len == '0) ? origin : stat.hit;
      res_overflow <= overflow;
    end
  end

endmodule

// File: rtl/wsm_checker.sv
module wsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [2:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // start and subject items put the block into its busy propagate state, where it takes no new item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1] |=> !s_tready)
    else $error("item taken while a match row is still settling");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'b0)
    else $error("padding bits of result not zero");

endmodule

bind wildcard_star_matcher_core wsm_checker u_wsm_checker (.*);
